// ===== hdl/rf_remote_pulse_width_decoder_macros.svh =====
// Assertion macros for the pulse-width remote decoder.
// Included by the top level; it has no other dependencies.
`ifndef RF_REMOTE_PULSE_WIDTH_DECODER_MACROS_SVH
`define RF_REMOTE_PULSE_WIDTH_DECODER_MACROS_SVH

// Implication checked in the same cycle, ignored while reset is held.
`define RFPWD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rfpwd check failed");

// Implication checked in the next cycle, ignored while reset is held.
`define RFPWD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rfpwd check failed");

`endif

// ===== hdl/rfpwd_pkg.sv =====
// Package for the pulse-width remote decoder: payload types, codes and reset values.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package rfpwd_pkg;

  localparam int CODE_BITS   = 24;
  localparam int QUEUE_DEPTH = 2;
  localparam int BITS_W      = 5;

  typedef enum logic [1:0] {
    CMD_EDGE          = 2'd0,
    CMD_HOLD_TICK     = 2'd1,
    CMD_INTERVAL_TICK = 2'd2,
    CMD_HANDLED       = 2'd3
  } cmd_t;

  localparam logic [2:0] REG_HEADER_MIN     = 3'd0;
  localparam logic [2:0] REG_HEADER_MAX     = 3'd1;
  localparam logic [2:0] REG_SHORT_MIN      = 3'd2;
  localparam logic [2:0] REG_SHORT_MAX      = 3'd3;
  localparam logic [2:0] REG_LONG_MIN       = 3'd4;
  localparam logic [2:0] REG_LONG_MAX       = 3'd5;
  localparam logic [2:0] REG_HOLD_TICKS     = 3'd6;
  localparam logic [2:0] REG_INTERVAL_TICKS = 3'd7;

  localparam logic [15:0] RST_HEADER_MIN     = 16'd8000;
  localparam logic [15:0] RST_HEADER_MAX     = 16'd14000;
  localparam logic [15:0] RST_SHORT_MIN      = 16'd200;
  localparam logic [15:0] RST_SHORT_MAX      = 16'd700;
  localparam logic [15:0] RST_LONG_MIN       = 16'd800;
  localparam logic [15:0] RST_LONG_MAX       = 16'd1600;
  localparam logic [7:0]  RST_HOLD_TICKS     = 8'd20;
  localparam logic [7:0]  RST_INTERVAL_TICKS = 8'd30;

  typedef struct packed {
    logic [1:0]  command;
    logic        pin_level;
    logic [15:0] timer_stamp;
  } in_t;

  typedef struct packed {
    logic       code_valid;
    logic [7:0] address_first;
    logic [7:0] address_second;
    logic [7:0] data_byte;
    logic       decode_enabled;
  } out_t;

  // Low-time windows used by the classifier.
  typedef struct packed {
    logic [15:0] header_min;
    logic [15:0] header_max;
    logic [15:0] short_min;
    logic [15:0] short_max;
    logic [15:0] long_min;
    logic [15:0] long_max;
  } win_t;

  // A classified request as it travels from classifier to decoder.
  typedef struct packed {
    logic [1:0] command;
    logic       pin_level;
    logic       header_hit;
    logic       bit_hit;
    logic       bit_one;
  } op_t;

endpackage

// ===== hdl/rfpwd_front.sv =====
// Classifier: keeps the low-period start stamp and sorts each request's low time.
// Depends on rfpwd_pkg.
`timescale 1ns / 1ps

module rfpwd_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  rfpwd_pkg::in_t   in_data,
  input  rfpwd_pkg::win_t  win,
  output rfpwd_pkg::op_t   op
);

  logic [15:0] low_start_r;
  logic [15:0] low_start_nxt;
  logic [15:0] len;
  logic        wrapped;

  // A wrapped period loses one tick: 0xffff - start + end.
  assign wrapped = low_start_r > in_data.timer_stamp;
  assign len     = in_data.timer_stamp - low_start_r - {15'd0, wrapped};

  always_comb begin
    low_start_nxt = low_start_r;
    if (accept && (in_data.command == rfpwd_pkg::CMD_EDGE) && !in_data.pin_level) begin
      low_start_nxt = in_data.timer_stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_start_r <= 16'd0;
    end else begin
      low_start_r <= low_start_nxt;
    end
  end

  always_comb begin
    op.command    = in_data.command;
    op.pin_level  = in_data.pin_level;
    op.header_hit = (len > win.header_min) && (len < win.header_max);
    op.bit_hit    = ((len > win.short_min) && (len < win.short_max)) ||
                    ((len > win.long_min) && (len < win.long_max));
    op.bit_one    = len < win.long_min;
  end

endmodule

// ===== hdl/rfpwd_queue.sv =====
// Short first-in first-out queue of classified requests.
// Depends on rfpwd_pkg.
`timescale 1ns / 1ps

module rfpwd_queue #(
  parameter int DEPTH = rfpwd_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rfpwd_pkg::op_t push_data,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output rfpwd_pkg::op_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rfpwd_pkg::op_t slot_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  assign full      = count_r == CW'(DEPTH);
  assign not_empty = count_r != '0;
  assign head      = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hdl/rfpwd_back.sv =====
// Frame decoder: bit assembly, repeat confirmation, lock counters and result register.
// Depends on rfpwd_pkg.
`timescale 1ns / 1ps

module rfpwd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            op_valid,
  input  rfpwd_pkg::op_t  op,
  output logic            op_pop,
  input  logic [7:0]      hold_ticks,
  input  logic [7:0]      interval_ticks,
  output logic            out_valid,
  input  logic            out_ready,
  output rfpwd_pkg::out_t out_data
);

  localparam int CB = rfpwd_pkg::CODE_BITS;
  localparam int BW = rfpwd_pkg::BITS_W;

  logic                  in_frame_r, in_frame_nxt;
  logic [BW-1:0]         bits_left_r, bits_left_nxt;
  logic [7:0]            addr_one_r, addr_one_nxt;
  logic [7:0]            addr_two_r, addr_two_nxt;
  logic [7:0]            shift_byte_r, shift_byte_nxt;
  logic [CB-1:0]         prev_code_r, prev_code_nxt;
  logic                  pending_r, pending_nxt;
  logic                  enabled_r, enabled_nxt;
  logic [7:0]            hold_r, hold_nxt;
  logic [7:0]            interval_r, interval_nxt;
  logic                  out_valid_r, out_valid_nxt;
  rfpwd_pkg::out_t       out_data_r, out_data_nxt;
  logic                  hit;
  logic [7:0]            sb;
  logic [CB-1:0]         code;

  assign op_pop    = op_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    in_frame_nxt   = in_frame_r;
    bits_left_nxt  = bits_left_r;
    addr_one_nxt   = addr_one_r;
    addr_two_nxt   = addr_two_r;
    shift_byte_nxt = shift_byte_r;
    prev_code_nxt  = prev_code_r;
    pending_nxt    = pending_r;
    enabled_nxt    = enabled_r;
    hold_nxt       = hold_r;
    interval_nxt   = interval_r;
    hit            = 1'b0;
    sb             = shift_byte_r;
    code           = {addr_one_r, addr_two_r, shift_byte_r};

    case (op.command)
      rfpwd_pkg::CMD_EDGE: begin
        if (op.pin_level && enabled_r) begin
          if (!in_frame_r) begin
            if (op.header_hit) begin
              bits_left_nxt  = BW'(CB);
              addr_one_nxt   = 8'd0;
              addr_two_nxt   = 8'd0;
              shift_byte_nxt = 8'd0;
              in_frame_nxt   = 1'b1;
            end
          end else if (!op.bit_hit) begin
            in_frame_nxt = 1'b0;
          end else begin
            // Whole bytes move out to the address registers before the next bit.
            if (bits_left_r == BW'(8)) begin
              addr_two_nxt = shift_byte_r;
              sb           = 8'd0;
            end
            if (bits_left_r == BW'(16)) begin
              addr_one_nxt = shift_byte_r;
              sb           = 8'd0;
            end
            shift_byte_nxt = {sb[6:0], op.bit_one};
            bits_left_nxt  = bits_left_r - 1'b1;
            code           = {addr_one_nxt, addr_two_nxt, shift_byte_nxt};
            if (bits_left_nxt == '0) begin
              hold_nxt     = hold_ticks;
              in_frame_nxt = 1'b0;
              if (!pending_r) begin
                prev_code_nxt = code;
                pending_nxt   = 1'b1;
              end else if (prev_code_r == code) begin
                pending_nxt = 1'b0;
                enabled_nxt = 1'b0;
                hit         = 1'b1;
              end else begin
                prev_code_nxt = code;
              end
            end
          end
        end
      end
      rfpwd_pkg::CMD_HOLD_TICK: begin
        if (hold_r != 8'd0) begin
          hold_nxt = hold_r - 1'b1;
          if (hold_r == 8'd1) begin
            enabled_nxt = 1'b1;
            pending_nxt = 1'b0;
          end
        end
      end
      rfpwd_pkg::CMD_INTERVAL_TICK: begin
        if (interval_r != 8'd0) begin
          interval_nxt = interval_r - 1'b1;
          if (interval_r == 8'd1) begin
            enabled_nxt = 1'b1;
          end
        end
      end
      rfpwd_pkg::CMD_HANDLED: begin
        interval_nxt = interval_ticks;
      end
      default: begin
      end
    endcase

    out_data_nxt.code_valid     = hit;
    out_data_nxt.address_first  = hit ? code[23:16] : 8'd0;
    out_data_nxt.address_second = hit ? code[15:8]  : 8'd0;
    out_data_nxt.data_byte      = hit ? code[7:0]   : 8'd0;
    out_data_nxt.decode_enabled = enabled_nxt;

    if (op_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r   <= 1'b0;
      bits_left_r  <= '0;
      addr_one_r   <= 8'd0;
      addr_two_r   <= 8'd0;
      shift_byte_r <= 8'd0;
      prev_code_r  <= '0;
      pending_r    <= 1'b0;
      enabled_r    <= 1'b1;
      hold_r       <= 8'd0;
      interval_r   <= 8'd0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (op_pop) begin
        in_frame_r   <= in_frame_nxt;
        bits_left_r  <= bits_left_nxt;
        addr_one_r   <= addr_one_nxt;
        addr_two_r   <= addr_two_nxt;
        shift_byte_r <= shift_byte_nxt;
        prev_code_r  <= prev_code_nxt;
        pending_r    <= pending_nxt;
        enabled_r    <= enabled_nxt;
        hold_r       <= hold_nxt;
        interval_r   <= interval_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op_pop) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// ===== hdl/rf_remote_pulse_width_decoder.sv =====
// Top level of the pulse-width RF remote decoder: configuration registers and the
// classifier, queue and decoder. Depends on rfpwd_pkg, rfpwd_front, rfpwd_queue,
// rfpwd_back and rf_remote_pulse_width_decoder_macros.svh.
//
//   Channel  Ports                          Moves
//   -------  -----------------------------  ----------------------------------------
//   input    in_valid / in_ready / in_data  one request: command, pin level, stamp
//   result   out_valid / out_ready / out_data  one result per request
//   config   cfg_we / cfg_index / cfg_wdata    register write, no wait, no read-back
//
// One request is taken per clock cycle while the queue is not full. Its result
// is registered: the classifier writes the queue at the accepting edge and the
// decoder writes the result register when it pops the request from the queue.
// Reset is synchronous and active low; there is no clearing pass after it.
// A stalled result only holds the decoder; the classifier keeps taking requests
// until the queue between the two is full.
`timescale 1ns / 1ps
`include "rf_remote_pulse_width_decoder_macros.svh"

module rf_remote_pulse_width_decoder #(
  parameter int QUEUE_DEPTH = rfpwd_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  rfpwd_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output rfpwd_pkg::out_t out_data,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [15:0]     cfg_wdata
);

  // Configuration registers. Windows go to the classifier, tick reloads to the
  // decoder. The user must write only while the block is idle (not enforced).
  rfpwd_pkg::win_t win_r, win_nxt;
  logic [7:0]      hold_ticks_r, hold_ticks_nxt;
  logic [7:0]      interval_ticks_r, interval_ticks_nxt;

  logic            accept;
  logic            q_full;
  logic            q_not_empty;
  logic            q_pop;
  rfpwd_pkg::op_t  front_op;
  rfpwd_pkg::op_t  q_head;

  logic            out_hit;
  logic            out_miss;
  logic            out_fields_zero;

  always_comb begin
    win_nxt            = win_r;
    hold_ticks_nxt     = hold_ticks_r;
    interval_ticks_nxt = interval_ticks_r;
    if (cfg_we) begin
      case (cfg_index)
        rfpwd_pkg::REG_HEADER_MIN:     win_nxt.header_min = cfg_wdata;
        rfpwd_pkg::REG_HEADER_MAX:     win_nxt.header_max = cfg_wdata;
        rfpwd_pkg::REG_SHORT_MIN:      win_nxt.short_min  = cfg_wdata;
        rfpwd_pkg::REG_SHORT_MAX:      win_nxt.short_max  = cfg_wdata;
        rfpwd_pkg::REG_LONG_MIN:       win_nxt.long_min   = cfg_wdata;
        rfpwd_pkg::REG_LONG_MAX:       win_nxt.long_max   = cfg_wdata;
        rfpwd_pkg::REG_HOLD_TICKS:     hold_ticks_nxt     = cfg_wdata[7:0];
        rfpwd_pkg::REG_INTERVAL_TICKS: interval_ticks_nxt = cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r.header_min <= rfpwd_pkg::RST_HEADER_MIN;
      win_r.header_max <= rfpwd_pkg::RST_HEADER_MAX;
      win_r.short_min  <= rfpwd_pkg::RST_SHORT_MIN;
      win_r.short_max  <= rfpwd_pkg::RST_SHORT_MAX;
      win_r.long_min   <= rfpwd_pkg::RST_LONG_MIN;
      win_r.long_max   <= rfpwd_pkg::RST_LONG_MAX;
      hold_ticks_r     <= rfpwd_pkg::RST_HOLD_TICKS;
      interval_ticks_r <= rfpwd_pkg::RST_INTERVAL_TICKS;
    end else begin
      win_r            <= win_nxt;
      hold_ticks_r     <= hold_ticks_nxt;
      interval_ticks_r <= interval_ticks_nxt;
    end
  end

  // The classifier owns the low-period start stamp, which only falling edges
  // change, so it can run ahead of the decoder without waiting on it.
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  rfpwd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_data (in_data),
    .win     (win_r),
    .op      (front_op)
  );

  rfpwd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (front_op),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // The decoder takes one queued request whenever its result register is free
  // or being emptied in the same cycle.
  rfpwd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .op_valid       (q_not_empty),
    .op             (q_head),
    .op_pop         (q_pop),
    .hold_ticks     (hold_ticks_r),
    .interval_ticks (interval_ticks_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data)
  );

  assign out_hit         = out_valid && out_data.code_valid;
  assign out_miss        = out_valid && !out_data.code_valid;
  assign out_fields_zero = (out_data.address_first == 8'd0) &&
                           (out_data.address_second == 8'd0) &&
                           (out_data.data_byte == 8'd0);

  // A confirmed code always locks the decoder.
  `RFPWD_ASSERT_NOW(a_valid_locks, clk, rst_n, out_hit, !out_data.decode_enabled)
  // Code bytes read as zero when no code was confirmed.
  `RFPWD_ASSERT_NOW(a_zero_fields, clk, rst_n, out_miss, out_fields_zero)
  // The queue can only fill up behind a held result.
  `RFPWD_ASSERT_NOW(a_full_needs_stall, clk, rst_n, !in_ready, out_valid)

endmodule
